// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the gate's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define EFG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed: lbl");

// Check a property on every rising edge, reset included.
`define EFG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed: lbl");

`endif

// ===== rtl/efg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efg_pkg
// Types and constants of the extent fencing token gate.
// ----------------------------------------------------------------------------
package efg_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int MAX_SCOPE     = 16;

    localparam int POS_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int AVAIL_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CNT_W   = $clog2(MAX_SCOPE + 2);
    localparam int SIDX_W  = (MAX_SCOPE > 1) ? $clog2(MAX_SCOPE) : 1;
    localparam int CMP_W   = (AVAIL_W > CNT_W) ? AVAIL_W : CNT_W;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FENCED   = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_NO_TOKEN = 3'd3,
        ST_NO_INC   = 3'd4,
        ST_TOO_BIG  = 3'd5,
        ST_FULL     = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_DECIDE,
        S_UPDATE,
        S_QUERY
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [63:0] token;
        logic [63:0] incarnation;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic shift;
        logic pass_end;
    } t_ctrl;

endpackage

// ===== rtl/efg_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efg_cell
// One table entry; hands its contents to the next cell on each shift.
// ----------------------------------------------------------------------------
module efg_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  efg_pkg::t_entry i_prev,
    output efg_pkg::t_entry o_entry
);

    logic        r_valid;
    logic [31:0] r_key;
    logic [63:0] r_token;
    logic [63:0] r_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key   <= i_prev.key;
            r_token <= i_prev.token;
            r_inc   <= i_prev.incarnation;
        end
    end

    assign o_entry = '{valid: r_valid, key: r_key, token: r_token, incarnation: r_inc};

endmodule

// ===== rtl/efg_scope.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efg_scope
// Key buffer of the open admit scope with duplicate and head-match compare.
// ----------------------------------------------------------------------------
module efg_scope (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [efg_pkg::SIDX_W-1:0]   i_wr_idx,
    input  logic [31:0]                  i_wr_key,
    input  logic [efg_pkg::CNT_W-1:0]    i_held,
    input  logic [31:0]                  i_probe_key,
    output logic                         o_dup,
    input  logic [31:0]                  i_head_key,
    output logic [efg_pkg::MAX_SCOPE-1:0] o_match,
    input  logic [efg_pkg::SIDX_W-1:0]   i_rd_idx,
    output logic [31:0]                  o_rd_key
);

    logic [31:0] r_keys [efg_pkg::MAX_SCOPE];
    logic [efg_pkg::MAX_SCOPE-1:0] dup_vec;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_keys[i_wr_idx] <= i_wr_key;
        end
    end

    always_comb begin
        for (int n = 0; n < efg_pkg::MAX_SCOPE; n++) begin
            dup_vec[n] = (efg_pkg::CNT_W'(n) < i_held) && (r_keys[n] == i_probe_key);
            o_match[n] = (efg_pkg::CNT_W'(n) < i_held) && (r_keys[n] == i_head_key);
        end
    end

    assign o_dup    = |dup_vec;
    assign o_rd_key = r_keys[i_rd_idx];

endmodule

// ===== rtl/extent_fencing_token_gate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extent_fencing_token_gate
// Per-extent fencing token table with admit scopes and high-water queries.
// ----------------------------------------------------------------------------
// The table sits in a ring of TABLE_ENTRIES cells that rotates one entry per
// cycle past a single compare/update head in check, update and query turns.
// An admit item without last is taken in idle and leaves busy low. A query
// keeps busy high for one ring turn and its result strobes in the cycle after.
// A last admit item passes an evaluation state, which rejects an invalid
// token, incarnation or scope size, then a check turn and a decide state,
// which rejects it on the gate or the capacity check, and an update turn when
// admitted. Results are shown for one cycle on o_valid; the receiver cannot
// stall them, and a new item may be started in that same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module extent_fencing_token_gate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_mode,
    input  logic [31:0] i_extent_key,
    input  logic [63:0] i_token,
    input  logic [63:0] i_incarnation,
    input  logic        i_last,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [63:0] o_detail,
    output logic [63:0] o_sequence_res,
    output logic [63:0] o_hw_token
);

    localparam int N = efg_pkg::TABLE_ENTRIES;
    localparam int M = efg_pkg::MAX_SCOPE;

    efg_pkg::t_state r_state, n_state;
    efg_pkg::t_ctrl  ctrl;

    logic [efg_pkg::POS_W-1:0]   r_pos;
    logic [efg_pkg::CNT_W-1:0]   r_count;
    logic [63:0]                 r_ptok, r_pinc, r_seq, r_qhw;
    logic [31:0]                 r_qkey, r_best_key;
    logic [M-1:0]                r_found, r_pend;
    logic [efg_pkg::AVAIL_W-1:0] r_avail;
    logic                        r_fail;
    logic [2:0]                  r_best_st;
    logic [63:0]                 r_best_det;

    logic        r_ov;
    logic [2:0]  r_status;
    logic [63:0] r_detail, r_seqres, r_hw;

    efg_pkg::t_entry chain [N];
    efg_pkg::t_entry head, wb;

    logic                       accept;
    logic [efg_pkg::CNT_W-1:0]  held;
    logic                       dup;
    logic [M-1:0]               match, count_mask;
    logic                       hit;
    logic [efg_pkg::SIDX_W-1:0] ins_idx;
    logic [31:0]                ins_key;
    logic [2:0]                 head_st;
    logic [63:0]                head_det;
    logic [efg_pkg::CNT_W-1:0]  found_cnt, fresh;
    logic                       invalid_req, full;

    assign accept = i_start && !ctrl.busy;
    assign head   = chain[N-1];
    assign held   = (r_count < efg_pkg::CNT_W'(M)) ? r_count : efg_pkg::CNT_W'(M);

    efg_scope u_scope (
        .i_clk       (i_clk),
        .i_wr_en     (accept && !i_mode && !dup && (r_count < efg_pkg::CNT_W'(M))),
        .i_wr_idx    (r_count[efg_pkg::SIDX_W-1:0]),
        .i_wr_key    (i_extent_key),
        .i_held      (held),
        .i_probe_key (i_extent_key),
        .o_dup       (dup),
        .i_head_key  (head.key),
        .o_match     (match),
        .i_rd_idx    (ins_idx),
        .o_rd_key    (ins_key)
    );

    for (genvar g = 0; g < N; g++) begin : g_ring
        if (g == 0) begin : g_first
            efg_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(ctrl.shift),
                .i_prev(wb), .o_entry(chain[g])
            );
        end else begin : g_rest
            efg_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(ctrl.shift),
                .i_prev(chain[g-1]), .o_entry(chain[g])
            );
        end
    end

    assign hit = head.valid && (|match);

    always_comb begin
        ins_idx = '0;
        for (int n = M - 1; n >= 0; n--) begin
            if (r_pend[n]) begin
                ins_idx = efg_pkg::SIDX_W'(n);
            end
        end
    end

    always_comb begin
        for (int n = 0; n < M; n++) begin
            count_mask[n] = efg_pkg::CNT_W'(n) < held;
        end
        found_cnt = '0;
        for (int n = 0; n < M; n++) begin
            found_cnt = found_cnt + efg_pkg::CNT_W'(r_found[n]);
        end
        fresh = held - found_cnt;
        full  = efg_pkg::CMP_W'(fresh) > efg_pkg::CMP_W'(r_avail);
        invalid_req = (r_ptok == '0) || (r_pinc == '0) || (r_count > efg_pkg::CNT_W'(M));
    end

    always_comb begin
        head_st  = efg_pkg::ST_OK;
        head_det = '0;
        if (head.token > r_ptok) begin
            head_st  = efg_pkg::ST_FENCED;
            head_det = head.token;
        end else if (head.token == r_ptok && head.incarnation != r_pinc) begin
            head_st  = efg_pkg::ST_CONFLICT;
            head_det = head.incarnation;
        end
    end

    // Write back the head entry, refreshed or newly filled during the update turn.
    always_comb begin
        wb = head;
        if (r_state == efg_pkg::S_UPDATE) begin
            if (hit) begin
                wb.token       = r_ptok;
                wb.incarnation = r_pinc;
            end else if (!head.valid && (|r_pend)) begin
                wb.valid       = 1'b1;
                wb.key         = ins_key;
                wb.token       = r_ptok;
                wb.incarnation = r_pinc;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            efg_pkg::S_IDLE: begin
                if (accept && i_mode) begin
                    n_state = efg_pkg::S_QUERY;
                end else if (accept && i_last) begin
                    n_state = efg_pkg::S_EVAL;
                end
            end
            efg_pkg::S_EVAL:   n_state = invalid_req ? efg_pkg::S_IDLE : efg_pkg::S_CHECK;
            efg_pkg::S_CHECK:  if (ctrl.pass_end) n_state = efg_pkg::S_DECIDE;
            efg_pkg::S_DECIDE: n_state = (r_fail || full) ? efg_pkg::S_IDLE : efg_pkg::S_UPDATE;
            efg_pkg::S_UPDATE: if (ctrl.pass_end) n_state = efg_pkg::S_IDLE;
            efg_pkg::S_QUERY:  if (ctrl.pass_end) n_state = efg_pkg::S_IDLE;
            default:           n_state = efg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        ctrl.busy     = r_state != efg_pkg::S_IDLE;
        ctrl.shift    = (r_state == efg_pkg::S_CHECK) || (r_state == efg_pkg::S_UPDATE) ||
                        (r_state == efg_pkg::S_QUERY);
        ctrl.pass_end = r_pos == efg_pkg::POS_W'(N - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= efg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_ptok  <= '0;
            r_pinc  <= '0;
            r_seq   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= 1'b0;
            if (ctrl.shift) begin
                r_pos <= ctrl.pass_end ? '0 : r_pos + 1'b1;
            end
            unique case (r_state)
                efg_pkg::S_IDLE: begin
                    if (accept && i_mode) begin
                        r_qkey <= i_extent_key;
                        r_qhw  <= '0;
                    end else if (accept) begin
                        if (r_count == '0) begin
                            r_ptok <= i_token;
                            r_pinc <= i_incarnation;
                        end
                        if (!dup) begin
                            r_count <= (r_count < efg_pkg::CNT_W'(M)) ? r_count + 1'b1
                                                                      : efg_pkg::CNT_W'(M + 1);
                        end
                    end
                end
                efg_pkg::S_EVAL: begin
                    r_found <= '0;
                    r_fail  <= 1'b0;
                    r_avail <= '0;
                    if (invalid_req) begin
                        r_ov     <= 1'b1;
                        r_seqres <= '0;
                        r_hw     <= '0;
                        r_count  <= '0;
                        r_detail <= '0;
                        if (r_ptok == '0) begin
                            r_status <= efg_pkg::ST_NO_TOKEN;
                        end else if (r_pinc == '0) begin
                            r_status <= efg_pkg::ST_NO_INC;
                        end else begin
                            r_status <= efg_pkg::ST_TOO_BIG;
                            r_detail <= 64'(r_count);
                        end
                    end
                end
                efg_pkg::S_CHECK: begin
                    r_found <= r_found | (match & {M{head.valid}});
                    if (!head.valid) begin
                        r_avail <= r_avail + 1'b1;
                    end
                    // Keep the failing extent with the smallest key.
                    if (hit && head_st != efg_pkg::ST_OK && (!r_fail || head.key < r_best_key)) begin
                        r_fail     <= 1'b1;
                        r_best_key <= head.key;
                        r_best_st  <= head_st;
                        r_best_det <= head_det;
                    end
                end
                efg_pkg::S_DECIDE: begin
                    r_pend <= count_mask & ~r_found;
                    if (r_fail || full) begin
                        r_ov     <= 1'b1;
                        r_seqres <= '0;
                        r_hw     <= '0;
                        r_count  <= '0;
                        r_status <= r_fail ? r_best_st : efg_pkg::ST_FULL;
                        r_detail <= r_fail ? r_best_det : '0;
                    end
                end
                efg_pkg::S_UPDATE: begin
                    if (!hit && !head.valid && (|r_pend)) begin
                        r_pend[ins_idx] <= 1'b0;
                    end
                    if (ctrl.pass_end) begin
                        r_ov     <= 1'b1;
                        r_seq    <= r_seq + 1'b1;
                        r_seqres <= r_seq + 1'b1;
                        r_hw     <= '0;
                        r_count  <= '0;
                        r_status <= efg_pkg::ST_OK;
                        r_detail <= '0;
                    end
                end
                efg_pkg::S_QUERY: begin
                    if (head.valid && head.key == r_qkey) begin
                        r_qhw <= head.token;
                    end
                    if (ctrl.pass_end) begin
                        r_ov     <= 1'b1;
                        r_status <= efg_pkg::ST_OK;
                        r_detail <= '0;
                        r_seqres <= '0;
                        r_hw     <= (head.valid && head.key == r_qkey) ? head.token : r_qhw;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_busy         = ctrl.busy;
    assign o_valid        = r_ov;
    assign o_status       = r_status;
    assign o_detail       = r_detail;
    assign o_sequence_res = r_seqres;
    assign o_hw_token     = r_hw;

    `EFG_ASSERT(a_strobe_idle, i_clk, i_rst_n, r_ov |-> (r_state == efg_pkg::S_IDLE))
    `EFG_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= efg_pkg::CNT_W'(M + 1))
    `EFG_ASSERT(a_pos_idle, i_clk, i_rst_n, (r_state == efg_pkg::S_IDLE) |-> (r_pos == '0))
    `EFG_ASSERT(a_query_busy, i_clk, i_rst_n, (accept && i_mode) |=> o_busy)
    `EFG_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_busy && !o_valid)

endmodule

// ===== bench/tb_extent_fencing_token_gate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_extent_fencing_token_gate
// Self-checking bench for the extent fencing token gate: admit scopes and
// high-water queries are predicted against a local copy of the extent table
// and every strobed result is compared field by field.
// ----------------------------------------------------------------------------
module tb_extent_fencing_token_gate;

    typedef struct {
        bit        mode;
        bit [31:0] key;
        bit [63:0] tok;
        bit [63:0] inc;
        bit        last;
        bit        drain;
    } t_gate_item;

    typedef struct {
        bit [2:0]  status;
        bit [63:0] detail;
        bit [63:0] seq;
        bit [63:0] hw;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_mode = 1'b0;
    logic [31:0] i_extent_key = '0;
    logic [63:0] i_token = '0;
    logic [63:0] i_incarnation = '0;
    logic        i_last = 1'b0;
    logic        o_busy;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [63:0] o_detail;
    logic [63:0] o_sequence_res;
    logic [63:0] o_hw_token;

    extent_fencing_token_gate u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_mode         (i_mode),
        .i_extent_key   (i_extent_key),
        .i_token        (i_token),
        .i_incarnation  (i_incarnation),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_detail       (o_detail),
        .o_sequence_res (o_sequence_res),
        .o_hw_token     (o_hw_token)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the extent table
    bit        tbl_valid [efg_pkg::TABLE_ENTRIES];
    bit [31:0] tbl_key   [efg_pkg::TABLE_ENTRIES];
    bit [63:0] tbl_tok   [efg_pkg::TABLE_ENTRIES];
    bit [63:0] tbl_inc   [efg_pkg::TABLE_ENTRIES];
    bit [31:0] open_keys [efg_pkg::MAX_SCOPE];
    int        open_cnt = 0;
    bit [63:0] open_tok = '0;
    bit [63:0] open_inc = '0;
    bit [63:0] issued_seq = '0;

    t_gate_item pending_items[$];
    t_verdict   awaited[$];
    int         errors = 0;
    int         idle_left = 0;
    int         stall_cnt = 0;

    function automatic int lookup_extent(bit [31:0] key);
        for (int i = 0; i < efg_pkg::TABLE_ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic t_verdict close_admit();
        t_verdict  v;
        int        fresh;
        int        avail;
        int        s;
        bit        found;
        bit [31:0] best_key;
        v = '{default: '0};
        fresh = 0;
        avail = 0;
        found = 1'b0;
        best_key = '0;
        if (open_tok == 0) begin
            v.status = efg_pkg::ST_NO_TOKEN;
            return v;
        end
        if (open_inc == 0) begin
            v.status = efg_pkg::ST_NO_INC;
            return v;
        end
        if (open_cnt > efg_pkg::MAX_SCOPE) begin
            v.status = efg_pkg::ST_TOO_BIG;
            v.detail = 64'(open_cnt);
            return v;
        end
        for (int n = 0; n < open_cnt; n++) begin
            bit [2:0]  st;
            bit [63:0] det;
            st = efg_pkg::ST_OK;
            det = '0;
            s = lookup_extent(open_keys[n]);
            if (s < 0) begin
                fresh++;
                continue;
            end
            if (tbl_tok[s] > open_tok) begin
                st = efg_pkg::ST_FENCED;
                det = tbl_tok[s];
            end else if (tbl_tok[s] == open_tok && tbl_inc[s] != open_inc) begin
                st = efg_pkg::ST_CONFLICT;
                det = tbl_inc[s];
            end
            // smallest failing key decides
            if (st != efg_pkg::ST_OK && (!found || open_keys[n] < best_key)) begin
                found = 1'b1;
                best_key = open_keys[n];
                v.status = st;
                v.detail = det;
            end
        end
        if (found)
            return v;
        for (int i = 0; i < efg_pkg::TABLE_ENTRIES; i++)
            if (!tbl_valid[i])
                avail++;
        if (fresh > avail) begin
            v.status = efg_pkg::ST_FULL;
            return v;
        end
        for (int n = 0; n < open_cnt; n++) begin
            s = lookup_extent(open_keys[n]);
            if (s < 0)
                for (int i = efg_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
                    if (!tbl_valid[i])
                        s = i;
            if (s < 0)
                continue;
            tbl_valid[s] = 1'b1;
            tbl_key[s] = open_keys[n];
            tbl_tok[s] = open_tok;
            tbl_inc[s] = open_inc;
        end
        issued_seq = issued_seq + 64'd1;
        v.status = efg_pkg::ST_OK;
        v.seq = issued_seq;
        return v;
    endfunction

    function automatic bit gate_predict(t_gate_item it, output t_verdict v);
        int s;
        int held;
        bit dup;
        v = '{default: '0};
        dup = 1'b0;
        if (it.mode) begin
            s = lookup_extent(it.key);
            v.hw = (s >= 0) ? tbl_tok[s] : 64'd0;
            return 1'b1;
        end
        if (open_cnt == 0) begin
            open_tok = it.tok;
            open_inc = it.inc;
        end
        held = (open_cnt < efg_pkg::MAX_SCOPE) ? open_cnt : efg_pkg::MAX_SCOPE;
        for (int n = 0; n < held; n++)
            if (open_keys[n] == it.key)
                dup = 1'b1;
        if (!dup) begin
            if (open_cnt < efg_pkg::MAX_SCOPE) begin
                open_keys[open_cnt] = it.key;
                open_cnt++;
            end else begin
                open_cnt = efg_pkg::MAX_SCOPE + 1;
            end
        end
        if (!it.last)
            return 1'b0;
        v = close_admit();
        open_cnt = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, bit [63:0] got, bit [63:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    // driver: one item per handshake, random idle bursts except near the end
    always @(posedge i_clk) begin
        t_verdict   v;
        t_gate_item it;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                it = '{i_mode, i_extent_key, i_token, i_incarnation, i_last, 1'b0};
                if (gate_predict(it, v))
                    awaited.insert(awaited.size(), v);
            end
            if (!i_start || !o_busy) begin
                if (idle_left > 0) begin
                    idle_left <= idle_left - 1;
                    i_start <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    i_start <= 1'b0;
                end else if (pending_items[0].drain && (awaited.size() != 0 || o_busy)) begin
                    i_start <= 1'b0;
                end else if (pending_items.size() > 150 && $urandom_range(0, 7) == 0) begin
                    idle_left <= $urandom_range(0, 4);
                    i_start <= 1'b0;
                end else begin
                    it = pending_items.pop_front();
                    i_start <= 1'b1;
                    i_mode <= it.mode;
                    i_extent_key <= it.key;
                    i_token <= it.tok;
                    i_incarnation <= it.inc;
                    i_last <= it.last;
                end
            end
        end
    end

    // monitor: every strobe must match the oldest expectation
    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && o_valid) begin
            if (awaited.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_status), 64'd0);
            end else begin
                v = awaited.pop_front();
                if (o_status !== v.status)
                    report_mismatch("status", 64'(o_status), 64'(v.status));
                if (o_detail !== v.detail)
                    report_mismatch("detail", o_detail, v.detail);
                if (o_sequence_res !== v.seq)
                    report_mismatch("sequence", o_sequence_res, v.seq);
                if (o_hw_token !== v.hw)
                    report_mismatch("hw_token", o_hw_token, v.hw);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > 4000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_item(bit mode, bit [31:0] key, bit [63:0] tok, bit [63:0] inc,
                            bit last);
        pending_items.insert(pending_items.size(), '{mode, key, tok, inc, last, 1'b0});
    endtask

    initial begin
        int        total;
        int        sz;
        bit        drain_set;
        bit [63:0] base;
        bit [63:0] tok;
        bit [63:0] inc;
        total = 0;
        drain_set = 1'b0;
        base = 64'd10;

        // directed part
        add_item(1'b1, 32'd0, '0, '0, 1'b1);                 // query of an absent extent
        add_item(1'b0, 32'd5, '0, 64'd1, 1'b1);              // token missing
        add_item(1'b0, 32'd5, 64'd3, '0, 1'b1);              // incarnation missing
        for (int k = 0; k < 18; k++)                          // oversized scope saturates
            add_item(1'b0, 32'(k), 64'd3, 64'd1, k == 17);
        add_item(1'b0, 32'd1, 64'd5, 64'd1, 1'b0);           // duplicate key in scope
        add_item(1'b0, 32'd1, rand64(), rand64(), 1'b0);
        add_item(1'b1, 32'd1, '0, '0, 1'b0);                 // query inside open scope
        add_item(1'b0, 32'd2, '1, '1, 1'b1);
        add_item(1'b0, 32'd1, 64'd5, 64'd2, 1'b1);           // owner conflict
        add_item(1'b0, 32'd2, 64'd4, 64'd1, 1'b0);           // two failures, smaller key wins
        add_item(1'b0, 32'd1, 64'd4, 64'd1, 1'b1);
        add_item(1'b0, 32'hFFFF_FFFF, '1, '1, 1'b1);         // extreme key and values
        add_item(1'b1, 32'hFFFF_FFFF, '1, '1, 1'b1);
        add_item(1'b1, 32'd1, '0, '0, 1'b0);

        // random part: mostly well-formed scopes over a small key pool
        while (total < 1400) begin
            case ($urandom_range(0, 9))
                0: begin
                    add_item(1'b1, ($urandom_range(0, 3) == 0) ? $urandom
                                                                : $urandom_range(0, 90),
                             rand64(), rand64(), 1'($urandom_range(0, 1)));
                    total++;
                end
                1: begin
                    add_item(1'b0, $urandom, rand64(), rand64(), 1'($urandom_range(0, 1)));
                    total++;
                end
                default: begin
                    sz = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 20)
                                                      : $urandom_range(1, 4);
                    if ($urandom_range(0, 1))
                        base = base + 64'd1;
                    tok = ($urandom_range(0, 29) == 0) ? 64'd0
                                                       : base + 64'($urandom_range(0, 2));
                    inc = ($urandom_range(0, 29) == 0) ? 64'd0 : 64'($urandom_range(1, 2));
                    for (int k = 0; k < sz; k++) begin
                        if (k == 0)
                            add_item(1'b0, $urandom_range(0, 90), tok, inc, sz == 1);
                        else
                            add_item(1'b0, $urandom_range(0, 90), rand64(), rand64(),
                                     k == sz - 1);
                        if (k < sz - 1 && $urandom_range(0, 15) == 0) begin
                            add_item(1'b1, $urandom_range(0, 90), rand64(), rand64(), 1'b1);
                            total++;
                        end
                    end
                    total += sz;
                end
            endcase
            // hold this item until every earlier result is in
            if (!drain_set && total > 700) begin
                pending_items[pending_items.size() - 1].drain = 1'b1;
                drain_set = 1'b1;
            end
        end
        add_item(1'b0, 32'd7, 64'd1, 64'd1, 1'b1);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do
            @(posedge i_clk);
        while (pending_items.size() != 0 || i_start || o_busy || awaited.size() != 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && awaited.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/efg_pkg.sv
rtl/efg_cell.sv
rtl/efg_scope.sv
rtl/extent_fencing_token_gate.sv
bench/tb_extent_fencing_token_gate.sv
